### sv/bbr_pkg.sv
// Shared types, constants and register codes of the box blur row filter.
`default_nettype none
package bbr_pkg;

	// Default sizing
	localparam int DEF_MAX_HALF = 32;
	localparam int DEF_MAX_ROW  = 4096;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HALF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RECIP_MUL   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RECIP_SHIFT = 2'd2;

	// Register reset values
	localparam logic [5:0]  RST_KERNEL_HALF = 6'd1;
	localparam logic [31:0] RST_RECIP_MUL   = 32'd5592406;
	localparam logic [4:0]  RST_RECIP_SHIFT = 5'd24;

	// Beat payloads
	typedef struct packed {
		logic [7:0] pixel_in;
		logic       row_end;
	} bbr_in_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic       row_done;
		logic       burst_last;
	} bbr_out_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_MUL,
		ST_EMIT,
		ST_FRD,
		ST_FUPD,
		ST_FMUL,
		ST_FEMIT
	} bbr_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;      // input beat accepted
		logic acc;       // main running-sum update
		logic mul;       // scale product into register
		logic mul_flush; // flags for a flush output
		logic fupd;      // flush running-sum update
		logic fnext;     // advance flush counters
		logic emit;      // load output register
		logic finish;    // close item, advance or clear row state
		logic rd_flush;  // ring read from flush address
	} bbr_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic emit_main;
		logic last;
		logic h_zero;
		logic e_ge_h;
		logic k_last;
		logic out_free;
	} bbr_sts_t;

endpackage
`default_nettype wire

### sv/bbr_if.sv
// Stream interfaces for input pixels and blurred results.
`default_nettype none
interface bbr_in_if;
	import bbr_pkg::*;
	logic    valid;
	logic    ready;
	bbr_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bbr_out_if;
	import bbr_pkg::*;
	logic     valid;
	logic     ready;
	bbr_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/bbr_cfg.sv
// Configuration registers: half width and reciprocal scaling.
`default_nettype none
module bbr_cfg import bbr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic [5:0]                 kernel_half,
	output logic [31:0]                recip_mul,
	output logic [4:0]                 recip_shift
);

	logic [5:0]  kernel_half_q;
	logic [31:0] recip_mul_q;
	logic [4:0]  recip_shift_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_half_q <= RST_KERNEL_HALF;
			recip_mul_q   <= RST_RECIP_MUL;
			recip_shift_q <= RST_RECIP_SHIFT;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_KERNEL_HALF: kernel_half_q <= cfg_data[5:0];
				CFG_RECIP_MUL:   recip_mul_q   <= cfg_data[31:0];
				CFG_RECIP_SHIFT: recip_shift_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign kernel_half = kernel_half_q;
	assign recip_mul   = recip_mul_q;
	assign recip_shift = recip_shift_q;

endmodule
`default_nettype wire

### sv/bbr_ctrl.sv
// Sequencer: main window update, scaling, output, and row-end flush.
`default_nettype none
module bbr_ctrl import bbr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire bbr_sts_t sts,
	output bbr_cmd_t      cmd
);

	bbr_state_t state_q;
	bbr_state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_ACC;
			end
			ST_ACC: begin
				if (sts.emit_main)  state_nxt = ST_MUL;
				else if (sts.last)  state_nxt = ST_FRD;
				else                state_nxt = ST_IDLE;
			end
			ST_MUL: state_nxt = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free) begin
					if (sts.last && !sts.h_zero) state_nxt = ST_FRD;
					else                         state_nxt = ST_IDLE;
				end
			end
			ST_FRD: state_nxt = ST_FUPD;
			ST_FUPD: begin
				if (sts.e_ge_h)      state_nxt = ST_FMUL;
				else if (sts.k_last) state_nxt = ST_IDLE;
				else                 state_nxt = ST_FRD;
			end
			ST_FMUL: state_nxt = ST_FEMIT;
			ST_FEMIT: begin
				if (sts.out_free) begin
					if (sts.k_last) state_nxt = ST_IDLE;
					else            state_nxt = ST_FRD;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_ACC: begin
				cmd.acc    = 1'b1;
				cmd.finish = !sts.emit_main && !sts.last;
			end
			ST_MUL: cmd.mul = 1'b1;
			ST_EMIT: begin
				cmd.emit   = sts.out_free;
				cmd.finish = sts.out_free && (!sts.last || sts.h_zero);
			end
			ST_FRD: cmd.rd_flush = 1'b1;
			ST_FUPD: begin
				cmd.fupd   = 1'b1;
				cmd.finish = !sts.e_ge_h && sts.k_last;
				cmd.fnext  = !sts.e_ge_h && !sts.k_last;
			end
			ST_FMUL: begin
				cmd.mul       = 1'b1;
				cmd.mul_flush = 1'b1;
			end
			ST_FEMIT: begin
				cmd.emit   = sts.out_free;
				cmd.finish = sts.out_free && sts.k_last;
				cmd.fnext  = sts.out_free && !sts.k_last;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### sv/bbr_dp.sv
// Datapath: pixel ring, running window sum, reciprocal scaling, output register.
`default_nettype none
module bbr_dp import bbr_pkg::*; #(
	parameter int MAX_HALF = DEF_MAX_HALF,
	parameter int MAX_ROW  = DEF_MAX_ROW
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire bbr_cmd_t    cmd,
	output bbr_sts_t         sts,
	input  wire logic [5:0]  kernel_half,
	input  wire logic [31:0] recip_mul,
	input  wire logic [4:0]  recip_shift,
	input  wire bbr_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output bbr_out_t         out_data
);

	localparam int RING   = 2 * MAX_HALF + 2;
	localparam int AW     = $clog2(RING);
	localparam int H_W    = $clog2(MAX_HALF + 1);
	localparam int SPAN_W = H_W + 1;
	localparam int SUM_W  = 8 + SPAN_W;
	localparam int POS_W  = $clog2(MAX_ROW);
	localparam int CMP_W  = $clog2(MAX_ROW + 2 * MAX_HALF + 2);

	// Row state
	logic [POS_W-1:0] pos_q;
	logic [AW-1:0]    head_q;
	logic [H_W-1:0]   h_q;
	logic [7:0]       first_q;
	logic [SUM_W-1:0] sum_q;

	// Item and flush working registers
	logic [7:0]       pix_q;
	logic             last_q;
	logic [H_W-1:0]   k_q;
	logic [CMP_W-1:0] e_q;
	logic [AW-1:0]    fl_addr_q;
	logic [31:0]      prod_q;
	logic             done_q;
	logic             blast_q;
	logic [7:0]       rd_q;

	// Output register
	logic             out_valid_q;
	bbr_out_t         out_q;

	logic [7:0]       ring_mem [RING];

	logic [H_W-1:0]    h_new;
	logic [SPAN_W-1:0] span;
	logic              pos_zero;
	logic [AW-1:0]     head_nxt;
	logic [AW-1:0]     main_addr;
	logic [AW-1:0]     rd_addr;
	logic [7:0]        old_main;
	logic [7:0]        old_flush;

	// Ring address span positions behind head plus one, modulo ring depth
	function automatic logic [AW-1:0] wrap_back(input logic [AW-1:0] head,
			input logic [SPAN_W-1:0] sp);
		logic [AW:0] t;
		t = (AW+1)'(head) + (AW+1)'(RING + 1) - (AW+1)'(sp);
		if (t >= (AW+1)'(RING)) t = t - (AW+1)'(RING);
		return t[AW-1:0];
	endfunction

	// Half width clamp, window span, ring addressing
	always_comb begin
		if (32'(kernel_half) > 32'(MAX_HALF)) h_new = H_W'(MAX_HALF);
		else                                  h_new = H_W'(kernel_half);
	end

	assign span      = {h_q, 1'b1};
	assign pos_zero  = (pos_q == '0);
	assign head_nxt  = pos_zero ? '0 :
		((head_q == AW'(RING - 1)) ? '0 : head_q + 1'b1);
	assign main_addr = wrap_back(head_q, span);
	assign rd_addr   = cmd.rd_flush ? fl_addr_q : main_addr;

	// Pixel leaving the window: from the ring once past the left edge
	assign old_main  = (CMP_W'(pos_q) >= CMP_W'(span)) ? rd_q : first_q;
	assign old_flush = (e_q >= CMP_W'(span)) ? rd_q : first_q;

	// Pixel ring, registered read
	always_ff @(posedge clk) begin
		if (cmd.load) ring_mem[head_nxt] <= in_data.pixel_in;
		rd_q <= ring_mem[rd_addr];
	end

	// Row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			head_q  <= '0;
			h_q     <= H_W'(1);
			first_q <= '0;
			sum_q   <= '0;
		end else begin
			if (cmd.load) begin
				head_q <= head_nxt;
				if (pos_zero) begin
					h_q     <= h_new;
					first_q <= in_data.pixel_in;
				end
			end
			// Running sum: cleared at row end, seeded from the row's first pixel, else main or flush update
			if (cmd.finish && last_q) begin
				sum_q <= '0;
			end else if (cmd.acc) begin
				if (pos_zero) sum_q <= SUM_W'(pix_q) * SUM_W'(span);
				else          sum_q <= sum_q + SUM_W'(pix_q) - SUM_W'(old_main);
			end else if (cmd.fupd) begin
				sum_q <= sum_q + SUM_W'(pix_q) - SUM_W'(old_flush);
			end
			if (cmd.finish) begin
				if (last_q) begin
					pos_q   <= '0;
					head_q  <= '0;
					first_q <= '0;
				end else if (pos_q != POS_W'(MAX_ROW - 1)) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	// Item capture, flush counters, product
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_q  <= in_data.pixel_in;
			last_q <= in_data.row_end;
		end
		if (cmd.acc) begin
			k_q       <= H_W'(1);
			e_q       <= CMP_W'(pos_q) + 1'b1;
			fl_addr_q <= wrap_back(head_q, span);
		end
		if (cmd.fnext) begin
			k_q       <= k_q + 1'b1;
			e_q       <= e_q + 1'b1;
			fl_addr_q <= (fl_addr_q == AW'(RING - 1)) ? '0 : fl_addr_q + 1'b1;
		end
		if (cmd.mul) begin
			prod_q <= 32'(32'(sum_q) * recip_mul);
			if (cmd.mul_flush) begin
				done_q  <= sts.k_last;
				blast_q <= sts.k_last;
			end else begin
				done_q  <= last_q && sts.h_zero;
				blast_q <= !last_q || sts.h_zero;
			end
		end
		if (cmd.emit) begin
			out_q.pixel_out  <= 8'(prod_q >> recip_shift);
			out_q.row_done   <= done_q;
			out_q.burst_last <= blast_q;
		end
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Status
	assign sts.emit_main = (CMP_W'(pos_q) >= CMP_W'(h_q));
	assign sts.last      = last_q;
	assign sts.h_zero    = (h_q == '0);
	assign sts.e_ge_h    = (e_q >= CMP_W'(h_q));
	assign sts.k_last    = (k_q == h_q);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

### sv/box_blur_row_filter.sv
// A pixel that completes a window passes accept, window update, multiply and output
// register; a beat with no result passes accept and window update only. A new beat is
// taken once the last is through; a stalled output register holds the sequence. Row
// end adds ring read, update, multiply, output register per flushed output, ring read
// and update per step without one, on the single ring read port and shared multiplier.
// Reset (arst_n low) clears row state, output valid and loads register defaults;
// the pixel ring is not cleared and is only read after being written in the row.
`default_nettype none
module box_blur_row_filter import bbr_pkg::*; #(
	parameter int MAX_HALF = DEF_MAX_HALF,
	parameter int MAX_ROW  = DEF_MAX_ROW
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	bbr_in_if.sink                     pixels,
	bbr_out_if.source                  blurred
);

	logic [5:0]  kernel_half;
	logic [31:0] recip_mul;
	logic [4:0]  recip_shift;
	bbr_cmd_t    cmd;
	bbr_sts_t    sts;
	logic        in_ready;

	bbr_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.kernel_half (kernel_half),
		.recip_mul   (recip_mul),
		.recip_shift (recip_shift)
	);

	bbr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixels.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bbr_dp #(
		.MAX_HALF (MAX_HALF),
		.MAX_ROW  (MAX_ROW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kernel_half (kernel_half),
		.recip_mul   (recip_mul),
		.recip_shift (recip_shift),
		.in_data     (pixels.data),
		.out_valid   (blurred.valid),
		.out_ready   (blurred.ready),
		.out_data    (blurred.data)
	);

	assign pixels.ready = in_ready;

endmodule
`default_nettype wire

### sv/bbr_checker.sv
// Port-level assertions for the box blur row filter, bound to the top level.
`default_nettype none
module bbr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_pixel,
	input wire logic       out_row_done,
	input wire logic       out_burst_last
);

	// A stalled output beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	// A stalled output beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_pixel) && $stable(out_row_done)
			&& $stable(out_burst_last))
		else $error("output payload changed while stalled");

	// The row's last output is always the last result of its input beat
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_row_done |-> out_burst_last)
		else $error("row_done without burst_last");

	// One pixel at a time: no accept in the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted back to back");

endmodule

bind box_blur_row_filter bbr_checker u_bbr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (pixels.valid),
	.in_ready       (pixels.ready),
	.out_valid      (blurred.valid),
	.out_ready      (blurred.ready),
	.out_pixel      (blurred.data.pixel_out),
	.out_row_done   (blurred.data.row_done),
	.out_burst_last (blurred.data.burst_last)
);
`default_nettype wire
